>>> rtl/core/thumbnail_ring_store_with_scaler_top_macros.svh
// Assertion helpers for the thumbnail ring store.
// Each macro checks a property on the rising edge of i_clk while i_rst_n is high.
`ifndef THUMBNAIL_RING_STORE_WITH_SCALER_TOP_MACROS_SVH
`define THUMBNAIL_RING_STORE_WITH_SCALER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define TRSS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("trss: implication check failed");

`define TRSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("trss: next-cycle check failed");

`else

`define TRSS_ASSERT_IMPL(label, ante, cons)
`define TRSS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/trss_pkg.sv
package trss_pkg;

    // Ring and thumbnail geometry.
    localparam int SLOTS        = 5;
    localparam int THUMB_WIDTH  = 40;
    localparam int THUMB_HEIGHT = 30;
    localparam int PIXEL_BITS   = 16;

    localparam int THUMB_AREA  = THUMB_WIDTH * THUMB_HEIGHT;
    localparam int STORE_DEPTH = SLOTS * THUMB_AREA;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Thumbnail cursors must be able to hold the width and height themselves.
    localparam int TX_W = $clog2(THUMB_WIDTH + 1);
    localparam int TY_W = $clog2(THUMB_HEIGHT + 1);

    // Fixed field widths of the stream payload.
    localparam int SIZE_W  = 12;
    localparam int COUNT_W = 3;
    localparam int INDEX_W = 3;
    localparam int RX_W    = 6;
    localparam int RY_W    = 5;

    // Products of a thumbnail coordinate and a source size.
    localparam int PX_W = SIZE_W + TX_W;
    localparam int PY_W = SIZE_W + TY_W;

    // Register indexes of the configuration port.
    localparam logic CFG_SRC_WIDTH  = 1'b0;
    localparam logic CFG_SRC_HEIGHT = 1'b1;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_READ  = 1'b1
    } t_opcode;

endpackage

>>> rtl/core/trss_ram.sv
module trss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/thumbnail_ring_store_with_scaler_top.sv
// Thumbnail ring store with a nearest-neighbor downscaler.
//
// The slave stream carries one command per transfer. tuser selects the kind:
// a store transfer brings one source pixel in raster order, a read transfer
// fetches one pixel of a stored thumbnail, photo index 0 being the newest.
// Every command gives exactly one result transfer on the master stream; tlast
// on a result marks the store that completed and committed a whole frame.
// The source size is set through the write port (index 0 width, 1 height).
//
// The block works on one command at a time. A read goes from the accepting
// edge straight to the done state, where its result is loaded. A store
// first searches for its cursor, starting from the hint left by the previous
// store unless it restarts, then writes each thumbnail entry that the source
// pixel covers through the single write port of the thumbnail memory, one
// covered thumbnail row after another.
// After a size change the search restarts from the thumbnail origin once.
// The result sits in an output register, so a stalled receiver only holds
// the next command back when its result is ready and the register is full.
// Synchronous reset empties the ring and restores the 320 x 240 source size;
// the thumbnail memory itself is not cleared.
`include "thumbnail_ring_store_with_scaler_top_macros.svh"

module thumbnail_ring_store_with_scaler_top
    import trss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,

    // Command stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] frame_start, [16:1] src_pixel, [19:17] photo_index, [25:20] read_x,
    // [30:26] read_y, [31] zero
    input  logic [31:0] s_axis_tdata,
    // [0] opcode
    input  logic        s_axis_tuser,

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] thumb_pixel, [18:16] photo_count, [23:19] zero
    output logic [23:0] m_axis_tdata,
    // [0] ok
    output logic        m_axis_tuser,
    // frame_done
    output logic        m_axis_tlast
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SKIP  = 4'b0010,
        ST_WRITE = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    // Unpacked command fields.
    logic                  w_frame_start;
    logic [PIXEL_BITS-1:0] w_src_pixel;
    logic [INDEX_W-1:0]    w_photo_index;
    logic [RX_W-1:0]       w_read_x;
    logic [RY_W-1:0]       w_read_y;
    t_opcode               w_opcode;

    assign w_frame_start = s_axis_tdata[0];
    assign w_src_pixel   = s_axis_tdata[16:1];
    assign w_photo_index = s_axis_tdata[19:17];
    assign w_read_x      = s_axis_tdata[25:20];
    assign w_read_y      = s_axis_tdata[30:26];
    assign w_opcode      = t_opcode'(s_axis_tuser);

    // Control state.
    t_state              r_state;
    logic [SIZE_W-1:0]   r_width;
    logic [SIZE_W-1:0]   r_height;
    logic [SIZE_W-1:0]   r_col;
    logic [SIZE_W-1:0]   r_row;
    logic [SLOT_W-1:0]   r_wslot;
    logic [COUNT_W-1:0]  r_count;
    logic [TX_W-1:0]     r_tx_hint;
    logic [TY_W-1:0]     r_ty_hint;
    logic                r_out_valid;

    // Per-command working registers.
    logic [TX_W-1:0]       r_tx;
    logic [TY_W-1:0]       r_ty;
    logic [TX_W-1:0]       r_tx_lo;
    logic [TY_W-1:0]       r_ty_lo;
    logic [TX_W-1:0]       r_tx_end;
    logic                  r_is_read;
    logic                  r_ok;
    logic [PIXEL_BITS-1:0] r_pixel;

    // Result register.
    logic                  r_out_ok;
    logic [PIXEL_BITS-1:0] r_out_pix;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_last;

    logic w_accept;
    logic w_load;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_load   = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    // Source position check at accept time: a new frame or a position that
    // no longer fits the current size restarts at the frame origin.
    logic w_size_zero;
    logic w_restart;
    assign w_size_zero = (r_width == '0) || (r_height == '0);
    assign w_restart   = w_frame_start || (r_col >= r_width) || (r_row >= r_height);

    // Thumbnail column tx maps to source column c when
    // c*THUMB_WIDTH <= tx*width < (c+1)*THUMB_WIDTH, rows alike.
    logic [PX_W-1:0] w_px;
    logic [PX_W-1:0] w_lowx;
    logic [PX_W-1:0] w_highx;
    logic [PY_W-1:0] w_py;
    logic [PY_W-1:0] w_lowy;
    logic [PY_W-1:0] w_highy;

    assign w_px    = PX_W'(r_tx) * PX_W'(r_width);
    assign w_lowx  = PX_W'(r_col) * PX_W'(THUMB_WIDTH);
    assign w_highx = w_lowx + PX_W'(THUMB_WIDTH);
    assign w_py    = PY_W'(r_ty) * PY_W'(r_height);
    assign w_lowy  = PY_W'(r_row) * PY_W'(THUMB_HEIGHT);
    assign w_highy = w_lowy + PY_W'(THUMB_HEIGHT);

    logic w_tx_room;
    logic w_ty_room;
    logic w_skip_x;
    logic w_skip_y;
    logic w_in_x;
    logic w_in_y;

    assign w_tx_room = r_tx < TX_W'(THUMB_WIDTH);
    assign w_ty_room = r_ty < TY_W'(THUMB_HEIGHT);
    assign w_skip_x  = w_tx_room && (w_px < w_lowx);
    assign w_skip_y  = w_ty_room && (w_py < w_lowy);
    assign w_in_x    = w_tx_room && (w_px < w_highx);
    assign w_in_y    = w_ty_room && (w_py < w_highy);

    // Thumbnail memory write, one entry per cycle while scattering.
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_waddr;

    assign w_ram_we = (r_state == ST_WRITE) && w_in_y && w_in_x;
    assign w_waddr  = ADDR_W'(r_wslot) * ADDR_W'(THUMB_AREA)
                    + ADDR_W'(r_ty) * ADDR_W'(THUMB_WIDTH)
                    + ADDR_W'(r_tx);

    // Read address: the newest photo sits one slot behind the write pointer.
    logic                  w_read_ok;
    logic [SLOT_W:0]       w_rsum;
    logic [SLOT_W-1:0]     w_rslot;
    logic [ADDR_W-1:0]     w_raddr;
    logic                  w_ram_re;
    logic [PIXEL_BITS-1:0] w_rdata;

    assign w_read_ok = (w_photo_index < r_count)
                    && (w_read_x < RX_W'(THUMB_WIDTH))
                    && (w_read_y < RY_W'(THUMB_HEIGHT));
    assign w_rsum    = (SLOT_W + 1)'(r_wslot) + (SLOT_W + 1)'(SLOTS - 1)
                     - (SLOT_W + 1)'(w_photo_index);
    assign w_rslot   = (w_rsum >= (SLOT_W + 1)'(SLOTS))
                     ? SLOT_W'(w_rsum - (SLOT_W + 1)'(SLOTS)) : SLOT_W'(w_rsum);
    assign w_raddr   = ADDR_W'(w_rslot) * ADDR_W'(THUMB_AREA)
                     + ADDR_W'(w_read_y) * ADDR_W'(THUMB_WIDTH)
                     + ADDR_W'(w_read_x);
    assign w_ram_re  = w_accept && (w_opcode == OP_READ);

    trss_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (r_pixel),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Frame advance once a store finishes.
    logic               w_col_last;
    logic               w_row_last;
    logic               w_store_upd;
    logic               w_commit;
    logic [SLOT_W-1:0]  w_wslot_next;
    logic [COUNT_W-1:0] w_count_next;

    assign w_col_last   = ({1'b0, r_col} + (SIZE_W + 1)'(1)) >= {1'b0, r_width};
    assign w_row_last   = ({1'b0, r_row} + (SIZE_W + 1)'(1)) >= {1'b0, r_height};
    assign w_store_upd  = !r_is_read && r_ok;
    assign w_commit     = w_store_upd && w_col_last && w_row_last;
    assign w_wslot_next = (r_wslot == SLOT_W'(SLOTS - 1)) ? '0 : r_wslot + 1'b1;
    assign w_count_next = (r_count < COUNT_W'(SLOTS)) ? r_count + 1'b1 : r_count;

    assign s_axis_tready = (r_state == ST_IDLE);

    // Sequencer and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= SIZE_W'(320);
            r_height    <= SIZE_W'(240);
            r_col       <= '0;
            r_row       <= '0;
            r_wslot     <= '0;
            r_count     <= '0;
            r_tx_hint   <= '0;
            r_ty_hint   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SRC_WIDTH:  r_width  <= i_cfg_data;
                    CFG_SRC_HEIGHT: r_height <= i_cfg_data;
                    default:        r_width  <= r_width;
                endcase
                // The cursor hints belong to the old size; search from the origin.
                r_tx_hint <= '0;
                r_ty_hint <= '0;
            end

            if (m_axis_tready && !w_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_opcode == OP_READ || w_size_zero) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_SKIP;
                            if (w_restart) begin
                                r_col <= '0;
                                r_row <= '0;
                            end
                        end
                    end
                end
                ST_SKIP: begin
                    if (!w_skip_x && !w_skip_y) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (!w_in_y) begin
                        r_state <= ST_DONE;
                    end else if (!w_in_x && r_tx == r_tx_lo) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                        if (w_store_upd) begin
                            if (w_col_last) begin
                                r_col     <= '0;
                                r_tx_hint <= '0;
                                if (w_row_last) begin
                                    r_row     <= '0;
                                    r_wslot   <= w_wslot_next;
                                    r_count   <= w_count_next;
                                    r_ty_hint <= '0;
                                end else begin
                                    r_row     <= r_row + 1'b1;
                                    r_ty_hint <= r_ty_lo;
                                end
                            end else begin
                                r_col     <= r_col + 1'b1;
                                r_tx_hint <= r_tx_end;
                                r_ty_hint <= r_ty_lo;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Scatter cursors and command payload.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_is_read <= (w_opcode == OP_READ);
                    r_ok      <= (w_opcode == OP_READ) ? w_read_ok : !w_size_zero;
                    r_pixel   <= w_src_pixel;
                    r_tx      <= w_restart ? '0 : r_tx_hint;
                    r_ty      <= w_restart ? '0 : r_ty_hint;
                end
            end
            ST_SKIP: begin
                if (w_skip_x) begin
                    r_tx <= r_tx + 1'b1;
                end
                if (w_skip_y) begin
                    r_ty <= r_ty + 1'b1;
                end
                if (!w_skip_x && !w_skip_y) begin
                    r_tx_lo  <= r_tx;
                    r_ty_lo  <= r_ty;
                    r_tx_end <= r_tx;
                end
            end
            ST_WRITE: begin
                if (w_in_y) begin
                    if (w_in_x) begin
                        r_tx <= r_tx + 1'b1;
                    end else begin
                        // End of the covered columns; move to the next covered row.
                        r_tx_end <= r_tx;
                        r_tx     <= r_tx_lo;
                        r_ty     <= r_ty + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                r_tx <= r_tx;
            end
            default: r_tx <= r_tx;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_ok    <= r_ok;
            r_out_pix   <= (r_is_read && r_ok) ? w_rdata : '0;
            r_out_count <= w_commit ? w_count_next : r_count;
            r_out_last  <= w_commit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_count, r_out_pix};
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tlast  = r_out_last;

    `TRSS_ASSERT_IMPL(a_write_in_thumb,
        w_ram_we, (r_tx < TX_W'(THUMB_WIDTH)) && (r_ty < TY_W'(THUMB_HEIGHT)))
    `TRSS_ASSERT_IMPL(a_ring_bounds,
        1'b1, (r_count <= COUNT_W'(SLOTS)) && (r_wslot < SLOT_W'(SLOTS)))
    `TRSS_ASSERT_NEXT(a_commit_advances,
        w_load && w_commit, (r_count == $past(w_count_next)) && (r_row == '0))
    `TRSS_ASSERT_IMPL(a_done_is_ok,
        m_axis_tvalid && m_axis_tlast, m_axis_tuser && (m_axis_tdata[15:0] == '0))

endmodule
